// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the sequencer RTL.
// Depends on a clock named clk and an active-low reset named rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`define ASSERT_IMPLY(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

// ===== rtl/qims_pkg.sv =====
// Package of the queued I2C master sequencer: request and result codes, item structs.
// Used by the front end, the back end and the top level; depends on nothing.
package qims_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int MAX_BYTES_DEF   = 32;

    localparam int LEN_W  = 7;
    localparam int STEP_W = 7;

    localparam int CMDQ_DEPTH = 2;
    localparam int RESQ_DEPTH = 2;

    localparam logic [1:0] REQ_SUBMIT = 2'd0;
    localparam logic [1:0] REQ_LOAD   = 2'd1;
    localparam logic [1:0] REQ_EVENT  = 2'd2;

    localparam logic [STEP_W-1:0] STEP_START   = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_ADDR_W  = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_REG     = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_RSTART  = STEP_W'(3);
    localparam logic [STEP_W-1:0] STEP_ADDR_R  = STEP_W'(4);
    localparam logic [STEP_W-1:0] STEP_RX_BASE = STEP_W'(5);

    typedef enum logic [1:0] {
        OP_SUBMIT,
        OP_LOAD,
        OP_EVENT,
        OP_NOP
    } op_t;

    typedef enum logic [1:0] {
        KIND_ACCEPT,
        KIND_REJECT,
        KIND_BUS,
        KIND_NOTHING
    } kind_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_START,
        CMD_SEND,
        CMD_RSTART,
        CMD_RECV,
        CMD_STOP
    } cmd_t;

    typedef struct packed {
        op_t              op;
        logic             is_read;
        logic [6:0]       device_addr;
        logic [7:0]       register_addr;
        logic [LEN_W-1:0] len;
        logic [7:0]       write_byte;
        logic [4:0]       write_index;
        logic [7:0]       rx_byte;
    } item_t;

    typedef struct packed {
        logic             is_read;
        logic [6:0]       device_addr;
        logic [7:0]       register_addr;
        logic [LEN_W-1:0] len;
    } hdr_t;

    typedef struct packed {
        kind_t      result_kind;
        cmd_t       bus_command;
        logic [7:0] tx_byte;
        logic       ack_bit;
        logic       read_valid;
        logic [7:0] read_data;
        logic [4:0] read_pos;
        logic       done_res;
        logic       done_was_read;
    } res_t;

endpackage

// ===== rtl/qims_fifo.sv =====
// Small first-in first-out queue of packed words, used between the stages of the sequencer.
// Depends on assert_macros.svh only; DEPTH must be a power of two.
`include "assert_macros.svh"

module qims_fifo #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [IW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [IW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == IW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(DEPTH), "Queue count exceeds its depth.")
    `ASSERT_IMPLY(a_count_step, $past(do_push) && !$past(do_pop),
        count_reg == $past(count_reg) + 1'b1, "A transfer in was not counted.")

endmodule

// ===== rtl/qims_front.sv =====
// Front end of the sequencer: decodes each incoming request and queues it for the back end.
// Depends on qims_pkg and qims_fifo.
`include "assert_macros.svh"

module qims_front
    import qims_pkg::*;
#(
    parameter int MAX_BYTES = MAX_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] req_type,
    input  logic       is_read,
    input  logic [6:0] device_addr,
    input  logic [7:0] register_addr,
    input  logic [5:0] byte_count,
    input  logic [7:0] write_byte,
    input  logic [4:0] write_index,
    input  logic [7:0] rx_byte,
    input  logic       cmd_pop,
    output logic       cmd_empty,
    output item_t      cmd_item
);

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BYTES);

    item_t             item;
    logic [LEN_W-1:0]  count_ext;
    logic [LEN_W-1:0]  index_ext;
    logic [$bits(item_t)-1:0] q_rdata;

    assign count_ext = LEN_W'(byte_count);
    assign index_ext = LEN_W'(write_index);

    always_comb
    begin
        item.is_read       = is_read;
        item.device_addr   = device_addr;
        item.register_addr = register_addr;
        item.len           = (count_ext > MAX_LEN) ? MAX_LEN : count_ext;
        item.write_byte    = write_byte;
        item.write_index   = write_index;
        item.rx_byte       = rx_byte;
        case (req_type)
            REQ_SUBMIT: item.op = OP_SUBMIT;
            REQ_LOAD:   item.op = (index_ext < MAX_LEN) ? OP_LOAD : OP_NOP;
            REQ_EVENT:  item.op = OP_EVENT;
            default:    item.op = OP_NOP;
        endcase
    end

    qims_fifo #(
        .DEPTH (CMDQ_DEPTH),
        .WIDTH ($bits(item_t))
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (item),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (q_rdata),
        .empty (cmd_empty)
    );

    assign cmd_item = item_t'(q_rdata);

    `ASSERT_IMPLY(a_load_in_range, push && !full && item.op == OP_LOAD,
        index_ext < MAX_LEN, "A load beyond the slot was classified as a store.")

endmodule

// ===== rtl/qims_back.sv =====
// Back end of the sequencer: transaction ring, staged data memory and the bus step logic.
// Depends on qims_pkg; takes decoded items from the front end and pushes one result each.
`include "assert_macros.svh"

module qims_back
    import qims_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int MAX_BYTES   = MAX_BYTES_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    input  item_t cmd_item,
    input  logic  cmd_empty,
    output logic  cmd_pop,
    input  logic  res_full,
    output logic  res_push,
    output res_t  res
);

    localparam int QW        = $clog2(QUEUE_DEPTH);
    localparam int MEM_DEPTH = QUEUE_DEPTH * MAX_BYTES;
    localparam int AW        = $clog2(MEM_DEPTH);

    typedef enum logic {
        S_FETCH,
        S_EXEC
    } state_t;

    state_t            state_reg, state_next;
    item_t             item_reg, item_next;
    logic [QW-1:0]     head_ptr_reg, head_ptr_next;
    logic [QW-1:0]     tail_ptr_reg, tail_ptr_next;
    logic              active_reg, active_next;
    logic [STEP_W-1:0] step_reg, step_next;
    hdr_t              hdr_reg [QUEUE_DEPTH];
    logic              hdr_we;

    logic [7:0]        data_mem [MEM_DEPTH];
    logic [7:0]        rd_data_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr, mem_raddr;

    hdr_t              cur_hdr, new_hdr;
    logic [QW-1:0]     head_inc, tail_inc;
    logic [STEP_W-1:0] step_m3, step_m5, pos_inc;
    logic [7:0]        addr_w, addr_r;
    logic              fin;

    assign cur_hdr  = hdr_reg[tail_ptr_reg];
    assign head_inc = (head_ptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : head_ptr_reg + 1'b1;
    assign tail_inc = (tail_ptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_ptr_reg + 1'b1;
    assign step_m3  = step_reg - STEP_RSTART;
    assign step_m5  = step_reg - STEP_RX_BASE;
    assign pos_inc  = step_m5 + 1'b1;
    assign addr_w   = {cur_hdr.device_addr, 1'b0};
    assign addr_r   = {cur_hdr.device_addr, 1'b1};

    assign new_hdr.is_read       = item_reg.is_read;
    assign new_hdr.device_addr   = item_reg.device_addr;
    assign new_hdr.register_addr = item_reg.register_addr;
    assign new_hdr.len           = item_reg.len;

    assign mem_raddr = AW'(tail_ptr_reg) * AW'(MAX_BYTES) + AW'(step_m3);
    assign mem_waddr = AW'(head_ptr_reg) * AW'(MAX_BYTES) + AW'(item_reg.write_index);

    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        head_ptr_next = head_ptr_reg;
        tail_ptr_next = tail_ptr_reg;
        active_next   = active_reg;
        step_next     = step_reg;
        hdr_we        = 1'b0;
        mem_we        = 1'b0;
        cmd_pop       = 1'b0;
        res_push      = 1'b0;
        fin           = 1'b0;
        res           = '0;
        res.result_kind = KIND_NOTHING;
        res.bus_command = CMD_NONE;
        case (state_reg)
            S_FETCH:
            begin
                if (!cmd_empty && !res_full)
                begin
                    cmd_pop    = 1'b1;
                    item_next  = cmd_item;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_push   = 1'b1;
                state_next = S_FETCH;
                case (item_reg.op)
                    OP_SUBMIT:
                    begin
                        if (head_inc == tail_ptr_reg)
                        begin
                            res.result_kind = KIND_REJECT;
                        end
                        else
                        begin
                            res.result_kind = KIND_ACCEPT;
                            hdr_we          = 1'b1;
                            head_ptr_next   = head_inc;
                            if (!active_reg)
                            begin
                                active_next     = 1'b1;
                                step_next       = STEP_ADDR_W;
                                res.bus_command = CMD_START;
                            end
                        end
                    end
                    OP_LOAD:
                    begin
                        mem_we = 1'b1;
                    end
                    OP_EVENT:
                    begin
                        if (active_reg)
                        begin
                            res.result_kind = KIND_BUS;
                            step_next       = step_reg + 1'b1;
                            if (step_reg == STEP_START)
                            begin
                                res.bus_command = CMD_START;
                            end
                            else if (step_reg == STEP_ADDR_W)
                            begin
                                res.bus_command = CMD_SEND;
                                res.tx_byte     = addr_w;
                            end
                            else if (step_reg == STEP_REG)
                            begin
                                res.bus_command = CMD_SEND;
                                res.tx_byte     = cur_hdr.register_addr;
                            end
                            else if (!cur_hdr.is_read)
                            begin
                                if (step_m3 < cur_hdr.len)
                                begin
                                    res.bus_command = CMD_SEND;
                                    res.tx_byte     = rd_data_reg;
                                end
                                else
                                begin
                                    fin = 1'b1;
                                end
                            end
                            else if (step_reg == STEP_RSTART)
                            begin
                                res.bus_command = CMD_RSTART;
                            end
                            else if (step_reg == STEP_ADDR_R)
                            begin
                                res.bus_command = CMD_SEND;
                                res.tx_byte     = addr_r;
                            end
                            else if (step_m5 < cur_hdr.len)
                            begin
                                res.bus_command = CMD_RECV;
                                res.ack_bit     = !(pos_inc < cur_hdr.len);
                                res.read_valid  = 1'b1;
                                res.read_data   = item_reg.rx_byte;
                                res.read_pos    = step_m5[4:0];
                            end
                            else
                            begin
                                fin = 1'b1;
                            end
                            if (fin)
                            begin
                                res.bus_command   = CMD_STOP;
                                res.done_res      = 1'b1;
                                res.done_was_read = cur_hdr.is_read;
                                tail_ptr_next     = tail_inc;
                                active_next       = (tail_inc != head_ptr_reg);
                                step_next         = '0;
                            end
                        end
                    end
                    default:
                    begin
                        res.result_kind = KIND_NOTHING;
                    end
                endcase
            end
            default:
            begin
                state_next = S_FETCH;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_FETCH;
            head_ptr_reg <= '0;
            tail_ptr_reg <= '0;
            active_reg   <= 1'b0;
            step_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            head_ptr_reg <= head_ptr_next;
            tail_ptr_reg <= tail_ptr_next;
            active_reg   <= active_next;
            step_reg     <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        if (hdr_we)
        begin
            hdr_reg[head_ptr_reg] <= new_hdr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            data_mem[mem_waddr] <= item_reg.write_byte;
        end
        if (cmd_pop)
        begin
            rd_data_reg <= data_mem[mem_raddr];
        end
    end

    `ASSERT_ALWAYS(a_active_ptrs, active_reg == (head_ptr_reg != tail_ptr_reg),
        "Active flag disagrees with the ring pointers.")
    `ASSERT_ALWAYS(a_ptr_range,
        (int'(head_ptr_reg) < QUEUE_DEPTH) && (int'(tail_ptr_reg) < QUEUE_DEPTH),
        "Ring pointer beyond the queue depth.")
    `ASSERT_IMPLY(a_push_room, res_push, !res_full, "Result pushed into a full queue.")
    `ASSERT_IMPLY(a_exec_after_pop, state_reg == S_EXEC, $past(cmd_pop),
        "Execution without a fetched item.")

endmodule

// ===== rtl/queued_i2c_master_sequencer.sv =====
// Top level of the queued I2C master register-transaction sequencer.
// Depends on qims_pkg, qims_front, qims_back and qims_fifo.
//
//   Channel   Handshake            Fields
//   request   push / full          req_type, is_read, device_addr, register_addr,
//                                  byte_count, write_byte, write_index, rx_byte
//   result    empty / pop          result_kind, bus_command, tx_byte, ack_bit, read_valid,
//                                  read_data, read_pos, done_res, done_was_read
//
// Each request gives exactly one result. The back end pops a request and reads the staged
// data memory in S_FETCH, then steps the transaction and writes the result in S_EXEC.
// The front end takes a transfer every cycle until its two-entry queue fills.
// After reset the block is ready at once; no memory clearing pass is needed.
// A full result queue stalls the back end, which in turn fills the request queue.

module queued_i2c_master_sequencer
    import qims_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int MAX_BYTES   = MAX_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] req_type,
    input  logic       is_read,
    input  logic [6:0] device_addr,
    input  logic [7:0] register_addr,
    input  logic [5:0] byte_count,
    input  logic [7:0] write_byte,
    input  logic [4:0] write_index,
    input  logic [7:0] rx_byte,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] result_kind,
    output logic [2:0] bus_command,
    output logic [7:0] tx_byte,
    output logic       ack_bit,
    output logic       read_valid,
    output logic [7:0] read_data,
    output logic [4:0] read_pos,
    output logic       done_res,
    output logic       done_was_read
);

    item_t cmd_item;
    logic  cmd_empty, cmd_pop;
    logic  res_full, res_push;
    res_t  res_in, res_out;
    logic [$bits(res_t)-1:0] res_rdata;

    qims_front #(
        .MAX_BYTES (MAX_BYTES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .req_type      (req_type),
        .is_read       (is_read),
        .device_addr   (device_addr),
        .register_addr (register_addr),
        .byte_count    (byte_count),
        .write_byte    (write_byte),
        .write_index   (write_index),
        .rx_byte       (rx_byte),
        .cmd_pop       (cmd_pop),
        .cmd_empty     (cmd_empty),
        .cmd_item      (cmd_item)
    );

    qims_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_BYTES   (MAX_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_item  (cmd_item),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    qims_fifo #(
        .DEPTH (RESQ_DEPTH),
        .WIDTH ($bits(res_t))
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign res_out       = res_t'(res_rdata);
    assign result_kind   = res_out.result_kind;
    assign bus_command   = res_out.bus_command;
    assign tx_byte       = res_out.tx_byte;
    assign ack_bit       = res_out.ack_bit;
    assign read_valid    = res_out.read_valid;
    assign read_data     = res_out.read_data;
    assign read_pos      = res_out.read_pos;
    assign done_res      = res_out.done_res;
    assign done_was_read = res_out.done_was_read;

endmodule
